/* src/nts_pkg.sv */
// Shared types and constants for the note table scaler.
package nts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int INDEX_SHIFT = 5;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 16;
  localparam int CFG_W       = 15;
  localparam int CFG_INDEX_W = 1;
  localparam int ENTRY_W     = 10;

  localparam logic [CFG_W-1:0] MIN_POSITION_RESET = 15'd0;
  localparam logic [CFG_W-1:0] MAX_POSITION_RESET = 15'd32736;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_LOOKUP    = 2'd1,
    OP_INCREMENT = 2'd2,
    OP_SEARCH    = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MIN_POSITION = 1'b0,
    CFG_MAX_POSITION = 1'b1
  } cfg_index_t;

endpackage

/* src/nts_item_if.sv */
// Input item channel: operation request beats.
interface nts_item_if;
  logic                              valid;
  logic                              ready;
  nts_pkg::op_t                      operation;
  logic [nts_pkg::ENTRY_W-1:0]       entry_index;
  logic signed [nts_pkg::VALUE_W-1:0] entry_value;
  logic signed [nts_pkg::POS_W-1:0]  position;
  logic signed [nts_pkg::POS_W-1:0]  step;
  logic signed [nts_pkg::VALUE_W-1:0] target;

  modport source (output valid, operation, entry_index, entry_value, position, step, target,
                  input ready);
  modport sink (input valid, operation, entry_index, entry_value, position, step, target,
                output ready);
endinterface

/* src/nts_result_if.sv */
// Result channel: one beat per accepted item.
interface nts_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [nts_pkg::VALUE_W-1:0] looked_up;
  logic signed [nts_pkg::POS_W-1:0]   new_position;

  modport source (output valid, looked_up, new_position, input ready);
  modport sink (input valid, looked_up, new_position, output ready);
endinterface

/* src/nts_table_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module nts_table_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/nts_pos_calc.sv */
// Position arithmetic: saturating increment, min/max clamp and table index.
module nts_pos_calc (
  input  logic                              increment,
  input  logic signed [nts_pkg::POS_W-1:0]  position,
  input  logic signed [nts_pkg::POS_W-1:0]  step,
  input  logic [nts_pkg::CFG_W-1:0]         min_position,
  input  logic [nts_pkg::CFG_W-1:0]         max_position,
  output logic [nts_pkg::ADDR_W-1:0]        addr,
  output logic signed [nts_pkg::POS_W-1:0]  new_position
);

  logic signed [nts_pkg::POS_W:0]   sum;
  logic signed [nts_pkg::POS_W-1:0] sat;
  logic signed [nts_pkg::POS_W-1:0] min_s;
  logic signed [nts_pkg::POS_W-1:0] max_s;
  logic signed [nts_pkg::POS_W-1:0] p;
  logic [nts_pkg::POS_W-2:0]        p_nn;
  logic [31:0]                      idx;

  always_comb begin
    sum   = {position[nts_pkg::POS_W-1], position} + {step[nts_pkg::POS_W-1], step};
    min_s = $signed({1'b0, min_position});
    max_s = $signed({1'b0, max_position});
    if (sum[nts_pkg::POS_W] != sum[nts_pkg::POS_W-1]) begin
      sat = sum[nts_pkg::POS_W] ? {1'b1, {(nts_pkg::POS_W-1){1'b0}}}
                                : {1'b0, {(nts_pkg::POS_W-1){1'b1}}};
    end else begin
      sat = sum[nts_pkg::POS_W-1:0];
    end
    // min first, then max: max wins when the two cross
    if (sat < min_s) begin
      sat = min_s;
    end
    if (sat > max_s) begin
      sat = max_s;
    end
    p    = increment ? sat : position;
    p_nn = p[nts_pkg::POS_W-1] ? '0 : p[nts_pkg::POS_W-2:0];
    idx  = 32'(p_nn) >> nts_pkg::INDEX_SHIFT;
    if (idx > 32'(nts_pkg::TABLE_DEPTH - 1)) begin
      idx = 32'(nts_pkg::TABLE_DEPTH - 1);
    end
    addr         = idx[nts_pkg::ADDR_W-1:0];
    new_position = increment ? sat : '0;
  end

endmodule

/* src/note_table_scaler_unit.sv */
// Note table scaler: ascending value table with lookup, clamped increment and inverse search.
// One item is in flight at a time. A write goes from acceptance to the finish state, a lookup
// or increment first through one table read, and an inverse search through one dependent read
// of the single table memory per search step. A finished result sits in the output register
// while the next item is accepted. The table has no reset; configuration writes are registered
// and apply to items accepted after them.
module note_table_scaler_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [nts_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nts_pkg::CFG_W-1:0]        cfg_data,
  nts_item_if.sink                         items,
  nts_result_if.source                     results
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t                            state;
  logic [nts_pkg::CFG_W-1:0]         min_position;
  logic [nts_pkg::CFG_W-1:0]         max_position;
  logic [nts_pkg::ADDR_W-1:0]        lo;
  logic [nts_pkg::ADDR_W-1:0]        hi;
  logic signed [nts_pkg::VALUE_W-1:0] target;
  logic signed [nts_pkg::VALUE_W-1:0] res_looked;
  logic signed [nts_pkg::POS_W-1:0]  res_pos;
  logic signed [nts_pkg::VALUE_W-1:0] out_looked;
  logic signed [nts_pkg::POS_W-1:0]  out_pos;
  logic                              out_valid;

  logic                              accept;
  logic                              ram_we;
  logic                              ram_re;
  logic [nts_pkg::ADDR_W-1:0]        ram_raddr;
  logic [nts_pkg::VALUE_W-1:0]       ram_q;
  logic [nts_pkg::ADDR_W-1:0]        pos_addr;
  logic signed [nts_pkg::POS_W-1:0]  pos_new;
  logic [nts_pkg::ADDR_W-1:0]        lo_next;
  logic [nts_pkg::ADDR_W-1:0]        hi_next;
  logic [nts_pkg::ADDR_W:0]          mid_sum;
  logic [nts_pkg::ADDR_W:0]          mid0_sum;
  logic                              search_more;
  logic                              out_free;

  localparam logic [nts_pkg::ADDR_W-1:0] HI_INIT = nts_pkg::ADDR_W'(nts_pkg::TABLE_DEPTH - 1);

  assign accept      = items.valid && items.ready;
  assign items.ready = (state == ST_IDLE);
  assign out_free    = !out_valid || results.ready;

  assign results.valid        = out_valid;
  assign results.looked_up    = out_looked;
  assign results.new_position = out_pos;

  nts_pos_calc u_pos_calc (
    .increment    (items.operation == nts_pkg::OP_INCREMENT),
    .position     (items.position),
    .step         (items.step),
    .min_position (min_position),
    .max_position (max_position),
    .addr         (pos_addr),
    .new_position (pos_new)
  );

  // search step: compare the returned midpoint, narrow the bounds, pick the next midpoint
  always_comb begin
    mid0_sum = (nts_pkg::ADDR_W + 1)'(HI_INIT);
    mid_sum  = (nts_pkg::ADDR_W + 1)'(lo) + (nts_pkg::ADDR_W + 1)'(hi);
    lo_next  = lo;
    hi_next  = hi;
    if (target >= $signed(ram_q)) begin
      lo_next = mid_sum[nts_pkg::ADDR_W:1];
    end else begin
      hi_next = mid_sum[nts_pkg::ADDR_W:1];
    end
    search_more = (hi_next - lo_next) > nts_pkg::ADDR_W'(1);
    mid_sum     = (nts_pkg::ADDR_W + 1)'(lo_next) + (nts_pkg::ADDR_W + 1)'(hi_next);
  end

  always_comb begin
    ram_we    = accept && (items.operation == nts_pkg::OP_WRITE)
                && (32'(items.entry_index) < 32'(nts_pkg::TABLE_DEPTH));
    ram_re    = 1'b0;
    ram_raddr = pos_addr;
    if (accept) begin
      case (items.operation)
        nts_pkg::OP_LOOKUP, nts_pkg::OP_INCREMENT: begin
          ram_re    = 1'b1;
          ram_raddr = pos_addr;
        end
        nts_pkg::OP_SEARCH: begin
          ram_re    = (nts_pkg::TABLE_DEPTH > 2);
          ram_raddr = mid0_sum[nts_pkg::ADDR_W:1];
        end
        default: begin
          ram_re = 1'b0;
        end
      endcase
    end else if (state == ST_SEARCH) begin
      ram_re    = search_more;
      ram_raddr = mid_sum[nts_pkg::ADDR_W:1];
    end
  end

  // reads and writes never overlap: only one item is in flight
  nts_table_ram #(
    .DEPTH (nts_pkg::TABLE_DEPTH),
    .WIDTH (nts_pkg::VALUE_W)
  ) u_table_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (items.entry_index[nts_pkg::ADDR_W-1:0]),
    .wdata (items.entry_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      min_position <= nts_pkg::MIN_POSITION_RESET;
      max_position <= nts_pkg::MAX_POSITION_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nts_pkg::CFG_MIN_POSITION: min_position <= cfg_data;
          nts_pkg::CFG_MAX_POSITION: max_position <= cfg_data;
          default: ;
        endcase
      end
      // in finish the output register is reloaded below whenever it frees up
      if (out_valid && results.ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_looked <= '0;
            res_pos    <= '0;
            target     <= items.target;
            lo         <= '0;
            hi         <= HI_INIT;
            case (items.operation)
              nts_pkg::OP_WRITE: state <= ST_FINISH;
              nts_pkg::OP_LOOKUP, nts_pkg::OP_INCREMENT: begin
                res_pos <= pos_new;
                state   <= ST_READ;
              end
              nts_pkg::OP_SEARCH: begin
                state <= (nts_pkg::TABLE_DEPTH > 2) ? ST_SEARCH : ST_FINISH;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end
        ST_READ: begin
          res_looked <= ram_q;
          state      <= ST_FINISH;
        end
        ST_SEARCH: begin
          lo <= lo_next;
          hi <= hi_next;
          if (!search_more) begin
            res_pos <= nts_pkg::POS_W'(32'(lo_next) << nts_pkg::INDEX_SHIFT);
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_looked <= res_looked;
            out_pos    <= res_pos;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result beat raised outside finish");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (hi > lo))
    else $error("search bounds crossed");

  a_write_finishes: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (state == ST_FINISH))
    else $error("table write not followed by result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_SEARCH) |-> !ram_we)
    else $error("table write during read or search");

endmodule
